// ===== rtl/core/swd_pkg.sv =====
// Shared types and constants for the swipe direction detector.
// Depends on nothing; imported by swd_classify and swipe_direction_detector.
package swd_pkg;

    // Width and reset value of the squared distance threshold register.
    localparam int unsigned THRESH_W     = 26;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10000);

    // Touch event kinds carried on the operation field.
    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_MOVE  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    // Result codes; DIR_NONE marks "no direction" in state and classifier output.
    typedef enum logic [2:0] {
        EV_UP       = 3'd0,
        EV_UP_LEFT  = 3'd1,
        EV_LEFT     = 3'd2,
        EV_RIGHT    = 3'd3,
        EV_UP_RIGHT = 3'd4,
        EV_RELEASE  = 3'd5,
        EV_CLICK    = 3'd6,
        DIR_NONE    = 3'd7
    } event_t;

    // Classifier result: whether the move beat the threshold, and its direction.
    typedef struct packed {
        logic   moved;
        event_t dir;
    } swd_move_t;

    // Directions that share a group do not retrigger a release.
    function automatic logic [1:0] dir_group(input event_t d);
        logic [1:0] grp;
        unique case (d)
            EV_UP:                   grp = 2'd0;
            EV_UP_LEFT, EV_LEFT:     grp = 2'd1;
            EV_RIGHT, EV_UP_RIGHT:   grp = 2'd2;
            default:                 grp = 2'd3;
        endcase
        return grp;
    endfunction

endpackage

// ===== rtl/core/swd_classify.sv =====
// Distance test and direction sorting for one touch move against the anchor.
// Depends on swd_pkg for the threshold width and the result codes.
module swd_classify
    import swd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 12
)
(
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,
    input  logic [COORD_WIDTH-1:0] anchor_x,
    input  logic [COORD_WIDTH-1:0] anchor_y,
    input  logic [THRESH_W-1:0]    threshold,
    output swd_move_t              result
);

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned SQ_W  = 2 * W + 1;
    localparam int unsigned CMP_W = (SQ_W > THRESH_W) ? SQ_W : THRESH_W;

    logic [W:0]      dx;
    logic [W:0]      dy;
    logic [W:0]      dx_negated;
    logic [W:0]      dy_negated;
    logic [W-1:0]    ax;
    logic [W-1:0]    ay;
    logic [2*W-1:0]  dx_sq;
    logic [2*W-1:0]  dy_sq;
    logic [SQ_W-1:0] dist_sq;
    logic [W:0]      ax_e;
    logic [W:0]      ay_e;
    logic [W:0]      ax2;
    logic [W:0]      ay2;
    logic            dx_neg;
    logic            dx_pos;
    logic            dy_pos;

    // Differences are W+1 bit two's complement, so they never overflow.
    assign dx = {1'b0, pos_x} - {1'b0, anchor_x};
    assign dy = {1'b0, pos_y} - {1'b0, anchor_y};
    assign dx_negated = ~dx + 1'b1;
    assign dy_negated = ~dy + 1'b1;
    assign ax = dx[W] ? dx_negated[W-1:0] : dx[W-1:0];
    assign ay = dy[W] ? dy_negated[W-1:0] : dy[W-1:0];

    assign dx_sq   = ax * ax;
    assign dy_sq   = ay * ay;
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

    assign dx_neg = dx[W];
    assign dx_pos = !dx[W] && (dx != '0);
    assign dy_pos = !dy[W] && (dy != '0);

    assign ax_e = {1'b0, ax};
    assign ay_e = {1'b0, ay};
    assign ax2  = {ax, 1'b0};
    assign ay2  = {ay, 1'b0};

    always_comb
    begin
        result.moved = CMP_W'(dist_sq) > CMP_W'(threshold);
        // Slope limits of one half and two, tested by cross multiplication.
        if (dy_pos && (ay_e > ax2))
        begin
            result.dir = EV_UP;
        end
        else if (dx_neg && dy_pos && (ay2 >= ax_e) && (ay_e <= ax2))
        begin
            result.dir = EV_UP_LEFT;
        end
        else if (dx_neg && (ay2 < ax_e))
        begin
            result.dir = EV_LEFT;
        end
        else if (dx_pos && (ay2 < ax_e))
        begin
            result.dir = EV_RIGHT;
        end
        else if (dx_pos && dy_pos && (ay2 >= ax_e) && (ay_e <= ax2))
        begin
            result.dir = EV_UP_RIGHT;
        end
        else
        begin
            result.dir = DIR_NONE;
        end
    end

endmodule

// ===== rtl/core/swipe_direction_detector.sv =====
// Swipe direction detector top level: input register, touch state and result buffer.
// Depends on swd_pkg and on swd_classify for the per-move distance and slope tests.
//
// Touch begin, move and end requests enter through the input channel and land in an
// input register; from there the classifier and the touch state logic settle the
// request and push its results (none, one or two) into a two-entry result buffer that
// drives the output channel. A request is accepted every cycle as long as the buffer
// has room for what the request in the input register produces, so a request that
// yields at most one result sustains one request per cycle while the output is not
// stalled, while a move that yields a release followed by a new direction is settled
// only once the buffer would be empty after the pop, and then fills both entries.
// The first result of a request is shown on the output once the request has passed
// the input register and reached the head of the result buffer. The squared distance
// threshold is written through the configuration channel, which is always ready, and
// must only be changed while no request is in flight.
module swipe_direction_detector
    import swd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             operation,
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             event_code,
    output logic                   last_of_run,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [THRESH_W-1:0]    cfg_data
);

    // Input register.
    logic                   in_valid_reg, in_valid_next;
    op_t                    op_reg;
    logic [COORD_WIDTH-1:0] px_reg;
    logic [COORD_WIDTH-1:0] py_reg;

    // Configuration and touch state.
    logic [THRESH_W-1:0]    thresh_reg;
    logic                   active_reg, active_next;
    logic                   held_reg, held_next;
    logic [COORD_WIDTH-1:0] anchor_x_reg, anchor_x_next;
    logic [COORD_WIDTH-1:0] anchor_y_reg, anchor_y_next;
    event_t                 last_dir_reg, last_dir_next;

    // Result buffer; entry 0 is the head shown on the output channel.
    logic [1:0]             ob_valid_reg, ob_valid_next;
    event_t                 ob_code_reg [2];
    event_t                 ob_code_next [2];
    logic [1:0]             ob_last_reg, ob_last_next;

    swd_move_t              move;
    logic                   accept;
    logic                   consume;
    logic                   pop;
    logic [1:0]             kept;
    logic [1:0]             res_count;
    event_t                 res_code0;
    event_t                 res_code1;

    swd_classify #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_classify (
        .pos_x     (px_reg),
        .pos_y     (py_reg),
        .anchor_x  (anchor_x_reg),
        .anchor_y  (anchor_y_reg),
        .threshold (thresh_reg),
        .result    (move)
    );

    assign cfg_ready = 1'b1;

    // The request in the input register is settled only when every one of its
    // results fits into the buffer after this cycle's pop.
    assign pop     = ob_valid_reg[0] && !out_stall;
    assign kept    = 2'(ob_valid_reg[0]) + 2'(ob_valid_reg[1]) - 2'(pop);
    assign consume = in_valid_reg && ((3'(kept) + 3'(res_count)) <= 3'd2);
    assign in_stall = in_valid_reg && !consume;
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // Touch state machine: results and next state for the request in the input register.
    always_comb
    begin
        res_count     = 2'd0;
        res_code0     = EV_RELEASE;
        res_code1     = EV_RELEASE;
        active_next   = active_reg;
        held_next     = held_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        last_dir_next = last_dir_reg;
        unique case (op_reg)
            OP_BEGIN:
            begin
                // A second begin during a touch is ignored.
                if (!active_reg)
                begin
                    active_next   = 1'b1;
                    anchor_x_next = px_reg;
                    anchor_y_next = py_reg;
                end
            end
            OP_MOVE:
            begin
                if (active_reg && move.moved)
                begin
                    if (!held_reg)
                    begin
                        // The first swipe latches the held flag even when it points down.
                        if (move.dir != DIR_NONE)
                        begin
                            res_count     = 2'd1;
                            res_code0     = move.dir;
                            last_dir_next = move.dir;
                        end
                        held_next = 1'b1;
                    end
                    else if ((move.dir != DIR_NONE) &&
                             (dir_group(move.dir) != dir_group(last_dir_reg)))
                    begin
                        res_count     = 2'd2;
                        res_code0     = EV_RELEASE;
                        res_code1     = move.dir;
                        last_dir_next = move.dir;
                    end
                    anchor_x_next = px_reg;
                    anchor_y_next = py_reg;
                end
            end
            OP_END:
            begin
                if (active_reg)
                begin
                    active_next = 1'b0;
                    res_count   = 2'd1;
                    if (held_reg)
                    begin
                        res_code0     = EV_RELEASE;
                        last_dir_next = DIR_NONE;
                        held_next     = 1'b0;
                    end
                    else
                    begin
                        res_code0 = EV_CLICK;
                    end
                end
            end
            default:
            begin
                // The unused operation code changes nothing.
            end
        endcase
    end

    // Buffer update: shift out the popped head, then append the new results.
    always_comb
    begin
        if (pop)
        begin
            ob_valid_next   = {1'b0, ob_valid_reg[1]};
            ob_code_next[0] = ob_code_reg[1];
            ob_code_next[1] = ob_code_reg[1];
            ob_last_next    = {1'b0, ob_last_reg[1]};
        end
        else
        begin
            ob_valid_next   = ob_valid_reg;
            ob_code_next[0] = ob_code_reg[0];
            ob_code_next[1] = ob_code_reg[1];
            ob_last_next    = ob_last_reg;
        end
        if (consume)
        begin
            if (res_count == 2'd2)
            begin
                ob_valid_next   = 2'b11;
                ob_code_next[0] = res_code0;
                ob_code_next[1] = res_code1;
                ob_last_next    = 2'b10;
            end
            else if (res_count == 2'd1)
            begin
                if (kept == 2'd0)
                begin
                    ob_valid_next[0] = 1'b1;
                    ob_code_next[0]  = res_code0;
                    ob_last_next[0]  = 1'b1;
                end
                else
                begin
                    ob_valid_next[1] = 1'b1;
                    ob_code_next[1]  = res_code0;
                    ob_last_next[1]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            thresh_reg   <= THRESH_RESET;
            active_reg   <= 1'b0;
            held_reg     <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            last_dir_reg <= DIR_NONE;
            ob_valid_reg <= 2'b00;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            ob_valid_reg <= ob_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
            if (consume)
            begin
                active_reg   <= active_next;
                held_reg     <= held_next;
                anchor_x_reg <= anchor_x_next;
                anchor_y_reg <= anchor_y_next;
                last_dir_reg <= last_dir_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(operation);
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
        ob_code_reg[0] <= ob_code_next[0];
        ob_code_reg[1] <= ob_code_next[1];
        ob_last_reg    <= ob_last_next;
    end

    assign out_valid   = ob_valid_reg[0];
    assign event_code  = ob_code_reg[0];
    assign last_of_run = ob_last_reg[0];

endmodule
